@@ src/snw_pkg.sv @@
// types and constants for the subsystem no-sleep watchdog
// no dependencies; imported by every module of the block
package snw_pkg;

  localparam int unsigned SumW = 40;
  localparam int unsigned CntW = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned NeedW = ValW + CntW;

  localparam logic [SumW-1:0] SumMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [ValW-1:0] ThresholdReset = 32'd1200;
  localparam logic [ValW-1:0] IntervalReset = 32'd7200;

  // register index on the config port
  localparam logic RegThreshold = 1'b0;
  localparam logic RegInterval = 1'b1;

  typedef enum logic [2:0] {
    ActMainReport  = 3'd0,
    ActModemReport = 3'd1,
    ActHubReport   = 3'd2,
    ActCheck       = 3'd3,
    ActManual      = 3'd4
  } action_e;

  typedef struct packed {
    logic [ValW-1:0] threshold;
    logic [ValW-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic            sub;
    logic [SumW-1:0] dur;
    logic [CntW-1:0] tot;
    logic            last;
  } evt_t;

  // events pushed by one processed item
  typedef struct packed {
    logic [1:0] num;
    evt_t       evt0;
    evt_t       evt1;
  } push_t;

endpackage

@@ src/snw_cfg_regs.sv @@
// apb-style configuration registers: trigger threshold and retrigger interval
// depends on snw_pkg
module snw_cfg_regs import snw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [ValW-1:0] threshold_q, threshold_d;
  logic [ValW-1:0] interval_q, interval_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    threshold_d = threshold_q;
    interval_d = interval_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegThreshold: threshold_d = pwdata;
        RegInterval:  interval_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegThreshold: prdata = threshold_q;
      RegInterval:  prdata = interval_q;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      interval_q <= IntervalReset;
    end else begin
      threshold_q <= threshold_d;
      interval_q <= interval_d;
    end
  end

  assign cfg_o.threshold = threshold_q;
  assign cfg_o.interval = interval_q;

endmodule

@@ src/snw_evt_fifo.sv @@
// four-entry event queue between the watchdog core and the output stream
// depends on snw_pkg
module snw_evt_fifo import snw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output evt_t  evt_o
);

  evt_t       mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;
  logic [1:0] wr_next;

  assign valid_o = (count_q != 3'd0);
  assign evt_o = mem_q[rd_ptr_q];
  assign pop = valid_o & ready_i;
  // room for the two events a check can raise
  assign room_o = (count_q <= 3'd2);
  assign wr_next = wr_ptr_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_ptr_q] <= push_i.evt0;
    if (push_i.num == 2'd2) mem_q[wr_next] <= push_i.evt1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.num;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + {1'b0, push_i.num} - {2'b0, pop};
    end
  end

endmodule

@@ src/snw_core.sv @@
// watchdog core: input register, sleep state, abnormal sums and trigger counts
// depends on snw_pkg
module snw_core import snw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      action_i,
  input  logic [ValW-1:0] value_i,
  input  logic            target_i,
  input  logic            room_i,
  output push_t           push_o
);

  logic            item_valid_q;
  logic [2:0]      action_q;
  logic [ValW-1:0] value_q;
  logic            target_q;

  logic [ValW-1:0] main_q, main_d;
  logic [ValW-1:0] modem_q, modem_d;
  logic [ValW-1:0] hub_q, hub_d;
  logic [ValW-1:0] hub_prev_q, hub_prev_d;
  logic [SumW-1:0] sum_q [2];
  logic [SumW-1:0] sum_d [2];
  logic [CntW-1:0] cnt_q [2];
  logic [CntW-1:0] cnt_d [2];

  logic [1:0]       slept;
  logic [1:0]       fire;
  logic [SumW:0]    sum_ext [2];
  logic [SumW-1:0]  sum_sat [2];
  logic [NeedW-1:0] need [2];
  logic             proc;

  assign proc = item_valid_q & room_i;
  assign in_ready_o = ~item_valid_q | proc;

  assign slept[0] = (modem_q != '0);
  assign slept[1] = (hub_q != hub_prev_q);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum_ext[l] = {1'b0, sum_q[l]} + {{(SumW+1-ValW){1'b0}}, main_q};
      sum_sat[l] = sum_ext[l][SumW] ? SumMax : sum_ext[l][SumW-1:0];
      need[l] = {{CntW{1'b0}}, cfg_i.interval} * {{ValW{1'b0}}, cnt_q[l]};
      fire[l] = ~slept[l] && (sum_sat[l] >= {{(SumW-ValW){1'b0}}, cfg_i.threshold})
                && ({{(NeedW-SumW){1'b0}}, sum_sat[l]} >= need[l]);
    end
  end

  always_comb begin
    main_d = main_q;
    modem_d = modem_q;
    hub_d = hub_q;
    hub_prev_d = hub_prev_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    push_o = '0;
    if (proc) begin
      case (action_q)
        ActMainReport:  main_d = value_q;
        ActModemReport: modem_d = value_q;
        ActHubReport:   hub_d = value_q;
        ActCheck: begin
          if (slept[1]) hub_prev_d = hub_q;
          for (int l = 0; l < 2; l++) begin
            if (slept[l]) begin
              sum_d[l] = '0;
              cnt_d[l] = '0;
            end else begin
              sum_d[l] = sum_sat[l];
              if (fire[l] && cnt_q[l] != CntMax) cnt_d[l] = cnt_q[l] + 1'b1;
            end
          end
          // modem event goes first when both fire
          push_o.evt0.sub = ~fire[0];
          push_o.evt0.dur = fire[0] ? sum_d[0] : sum_d[1];
          push_o.evt0.tot = fire[0] ? cnt_d[0] : cnt_d[1];
          push_o.evt0.last = ~(fire[0] & fire[1]);
          push_o.evt1.sub = 1'b1;
          push_o.evt1.dur = sum_d[1];
          push_o.evt1.tot = cnt_d[1];
          push_o.evt1.last = 1'b1;
          push_o.num = {1'b0, fire[0]} + {1'b0, fire[1]};
        end
        ActManual: begin
          push_o.num = 2'd1;
          push_o.evt0.sub = target_q;
          push_o.evt0.dur = sum_q[target_q];
          push_o.evt0.tot = cnt_q[target_q];
          push_o.evt0.last = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      value_q <= value_i;
      target_q <= target_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      main_q <= '0;
      modem_q <= '0;
      hub_q <= '0;
      hub_prev_q <= '0;
      for (int l = 0; l < 2; l++) begin
        sum_q[l] <= '0;
        cnt_q[l] <= '0;
      end
    end else begin
      if (in_ready_o) item_valid_q <= in_valid_i;
      main_q <= main_d;
      modem_q <= modem_d;
      hub_q <= hub_d;
      hub_prev_q <= hub_prev_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ src/subsystem_nosleep_watchdog_core.sv @@
// top level of the subsystem no-sleep watchdog
// depends on snw_pkg, snw_cfg_regs, snw_core, snw_evt_fifo
//
//   channel   direction  beat contents
//   s_axis    in         sleep report, check or manual trigger
//   m_axis    out        no-sleep event, tlast on the final event of an item
//   apb       in/out     threshold and retrigger interval registers
//
// an item is processed once it sits in the input register and the queue has room;
// state and events are written at the next edge, after which an event can leave;
// a new item is taken every cycle while the queue has room for two events
// events leave at one per cycle while m_axis is ready; a check firing both subsystems
// pushes two; the four-entry queue absorbs short m_axis stalls, then input waits
// reset clears all sleep state, sums and counts and loads the register defaults
module subsystem_nosleep_watchdog_core import snw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // report_value
  input  logic [3:0]  s_axis_tuser,   // action[2:0], target_subsystem[3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // abnormal_duration[39:0], trigger_total[55:40]
  output logic [0:0]  m_axis_tuser,   // event_subsystem
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  push_t push;
  evt_t  evt;
  logic  room;

  snw_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  snw_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser[2:0]),
    .value_i    (s_axis_tdata),
    .target_i   (s_axis_tuser[3]),
    .room_i     (room),
    .push_o     (push)
  );

  snw_evt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .evt_o   (evt)
  );

  assign m_axis_tdata = {evt.tot, evt.dur};
  assign m_axis_tuser = evt.sub;
  assign m_axis_tlast = evt.last;

endmodule
